/* hdl/kmhs_pkg.sv */
// package for the k-way merge heap selector: item types, codes and the rank compare
`default_nettype none
package kmhs_pkg;

	localparam int MAX_SOURCES_DEF = 16;
	localparam int KEY_BITS_DEF    = 64;

	// command codes
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_BUILD   = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;

	// configuration port
	localparam int         CFG_IDX_W   = 1;
	localparam int         CFG_DATA_W  = 5;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 1'b1;
	localparam logic [4:0] COUNT_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  source_index;
		logic [63:0] head_key;
		logic        head_present;
	} in_t;

	typedef struct packed {
		logic        has_winner;
		logic [3:0]  winner_index;
		logic [63:0] winner_key;
	} out_t;

	// true if entry a must sit above entry b; ties go to the lower source
	function automatic logic ranks_before(logic rev, logic [63:0] ka, logic [7:0] ia,
			logic [63:0] kb, logic [7:0] ib);
		logic r;
		if (ka != kb) begin
			r = rev ? (ka > kb) : (ka < kb);
		end else begin
			r = (ia < ib);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/kway_merge_heap_selector.sv */
// k-way merge selector: source heads plus a binary heap of live sources, one shared compare
// Usage: input items arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data, registers are written through cfg_we/cfg_index/cfg_data.
// A load item writes one source head and gives no result; build and advance items give
// exactly one result. The block takes one item at a time: in_stall is high from the cycle
// after a build or advance item is taken until its work is done.
// The heap sequencer does at most one heap memory access and at most one key compare per
// cycle. A load is done in the idle state; build scans each source below source_count,
// loads the head key of each live source and sifts it up, then reports; advance moves the
// last heap entry to the root in place of the winner and sifts it down, pushes the winner's
// source again if its new head is present and sifts that up, then reports.
// The result sits in an output register; the block takes the next item while it waits,
// and only a further result holds in the report step until out_stall drops.
// Reset (arst_n low) empties the heap, marks all sources exhausted, clears reverse_order
// and sets source_count to 16; head keys are unknown until loaded.
// A load or any register write empties the heap, so a build is needed before the next
// advance; an advance with no current winner reports no winner.
`default_nettype none
module kway_merge_heap_selector #(
	parameter int MAX_SOURCES = kmhs_pkg::MAX_SOURCES_DEF,
	parameter int KEY_BITS    = kmhs_pkg::KEY_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire kmhs_pkg::in_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output kmhs_pkg::out_t                      out_data,
	input  wire logic                           cfg_we,
	input  wire logic [kmhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kmhs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kmhs_pkg::*;

	localparam int SRC_W  = $clog2(MAX_SOURCES);
	localparam int FILL_W = $clog2(MAX_SOURCES + 1);
	localparam int LW     = SRC_W + 1;

	typedef struct packed {
		logic [SRC_W-1:0]    src;
		logic [KEY_BITS-1:0] key;
	} ent_t;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_BLD_CHK = 4'd1;
	localparam logic [3:0] S_BLD_LD  = 4'd2;
	localparam logic [3:0] S_SU_RD   = 4'd3;
	localparam logic [3:0] S_SU_CMP  = 4'd4;
	localparam logic [3:0] S_POP_RD  = 4'd5;
	localparam logic [3:0] S_POP_LD  = 4'd6;
	localparam logic [3:0] S_SD_RDL  = 4'd7;
	localparam logic [3:0] S_SD_RDR  = 4'd8;
	localparam logic [3:0] S_SD_CMPR = 4'd9;
	localparam logic [3:0] S_SD_CMPP = 4'd10;
	localparam logic [3:0] S_PUSH    = 4'd11;
	localparam logic [3:0] S_REP_RD  = 4'd12;
	localparam logic [3:0] S_REP_OUT = 4'd13;

	logic [3:0]          state_q;
	logic                reverse_q;
	logic [4:0]          count_q;
	logic                live_q [MAX_SOURCES];
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   scan_q;
	logic [SRC_W-1:0]    cur_src_q;
	logic                cur_valid_q;
	logic                build_mode_q;
	logic                present_q;
	ent_t                new_ent_q;
	ent_t                x_q;
	ent_t                c_q;
	logic [SRC_W-1:0]    p_q;
	logic [SRC_W-1:0]    cpos_q;
	logic                out_valid_q;
	out_t                out_q;

	// memories
	logic [KEY_BITS-1:0] key_mem [MAX_SOURCES];
	logic [KEY_BITS-1:0] key_rd_q;
	ent_t                heap_mem [MAX_SOURCES];
	ent_t                hrd_q;

	logic                kw_en, kr_en, hw_en, hr_en;
	logic [SRC_W-1:0]    kw_addr, hw_addr, hr_addr;
	logic [KEY_BITS-1:0] kw_data;
	ent_t                hw_data;

	logic                in_acc;
	logic                load_in_range;
	logic                can_pop;
	logic [FILL_W-1:0]   limit;
	logic [LW-1:0]       l_w;
	logic [LW:0]         r_w;
	logic                l_ok, r_ok;
	logic [SRC_W-1:0]    par;
	ent_t                cmp_a, cmp_b;
	logic                cmp_lt;
	logic                rep_load;
	logic [KEY_BITS-1:0] in_key;

	assign in_stall      = (state_q != S_IDLE);
	assign in_acc        = in_valid && !in_stall;
	assign in_key        = in_data.head_key[KEY_BITS-1:0];
	assign load_in_range = (32'(in_data.source_index) < MAX_SOURCES);
	assign can_pop       = cur_valid_q && (fill_q != '0);
	assign limit         = (32'(count_q) > MAX_SOURCES) ? FILL_W'(MAX_SOURCES)
	                                                    : FILL_W'(count_q);
	assign l_w           = {p_q, 1'b1};
	assign r_w           = (LW+1)'(l_w) + (LW+1)'(1);
	assign l_ok          = (l_w < LW'(fill_q));
	assign r_ok          = (r_w < (LW+1)'(fill_q));
	assign par           = SRC_W'((p_q - SRC_W'(1)) >> 1);
	assign rep_load      = (state_q == S_REP_OUT) && (!out_valid_q || !out_stall);
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	// the one shared rank compare
	always_comb begin
		unique case (state_q)
			S_SD_CMPR: begin
				cmp_a = hrd_q;
				cmp_b = c_q;
			end
			S_SD_CMPP: begin
				cmp_a = c_q;
				cmp_b = x_q;
			end
			default: begin
				cmp_a = x_q;
				cmp_b = hrd_q;
			end
		endcase
		cmp_lt = ranks_before(reverse_q, 64'(cmp_a.key), 8'(cmp_a.src),
				64'(cmp_b.key), 8'(cmp_b.src));
	end

	// memory strobes
	always_comb begin
		kw_en   = 1'b0;
		kw_addr = SRC_W'(in_data.source_index);
		kw_data = in_key;
		kr_en   = 1'b0;
		hw_en   = 1'b0;
		hw_addr = p_q;
		hw_data = x_q;
		hr_en   = 1'b0;
		hr_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_data.command == CMD_LOAD && load_in_range) begin
					kw_en = 1'b1;
				end else if (in_acc && in_data.command == CMD_ADVANCE && can_pop) begin
					kw_en   = 1'b1;
					kw_addr = cur_src_q;
				end
			end
			S_BLD_CHK: begin
				kr_en = (scan_q != limit) && live_q[scan_q[SRC_W-1:0]];
			end
			S_SU_RD: begin
				if (p_q == '0) begin
					hw_en = 1'b1;
				end else begin
					hr_en   = 1'b1;
					hr_addr = par;
				end
			end
			S_SU_CMP: begin
				hw_en   = 1'b1;
				hw_data = cmp_lt ? hrd_q : x_q;
			end
			S_POP_RD: begin
				hr_en   = 1'b1;
				hr_addr = SRC_W'(fill_q - FILL_W'(1));
			end
			S_SD_RDL: begin
				if (!l_ok) begin
					hw_en = 1'b1;
				end else begin
					hr_en   = 1'b1;
					hr_addr = SRC_W'(l_w);
				end
			end
			S_SD_RDR: begin
				if (r_ok) begin
					hr_en   = 1'b1;
					hr_addr = SRC_W'(r_w);
				end
			end
			S_SD_CMPP: begin
				hw_en   = 1'b1;
				hw_data = cmp_lt ? c_q : x_q;
			end
			S_REP_RD: begin
				hr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (kw_en) begin
			key_mem[kw_addr] <= kw_data;
		end
		if (kr_en) begin
			key_rd_q <= key_mem[scan_q[SRC_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (hw_en) begin
			heap_mem[hw_addr] <= hw_data;
		end
		if (hr_en) begin
			hrd_q <= heap_mem[hr_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			reverse_q    <= 1'b0;
			count_q      <= COUNT_RESET;
			for (int i = 0; i < MAX_SOURCES; i++) begin
				live_q[i] <= 1'b0;
			end
			fill_q       <= '0;
			scan_q       <= '0;
			cur_src_q    <= '0;
			cur_valid_q  <= 1'b0;
			build_mode_q <= 1'b0;
			present_q    <= 1'b0;
			new_ent_q    <= '0;
			x_q          <= '0;
			c_q          <= '0;
			p_q          <= '0;
			cpos_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rep_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_REVERSE: reverse_q <= cfg_data[0];
					REG_COUNT:   count_q   <= cfg_data;
				endcase
				fill_q      <= '0;
				cur_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_data.command)
							CMD_LOAD: begin
								if (load_in_range) begin
									live_q[SRC_W'(in_data.source_index)] <=
										in_data.head_present;
								end
								fill_q      <= '0;
								cur_valid_q <= 1'b0;
							end
							CMD_BUILD: begin
								fill_q       <= '0;
								scan_q       <= '0;
								build_mode_q <= 1'b1;
								state_q      <= S_BLD_CHK;
							end
							CMD_ADVANCE: begin
								build_mode_q <= 1'b0;
								if (can_pop) begin
									live_q[cur_src_q] <= in_data.head_present;
									present_q         <= in_data.head_present;
									new_ent_q         <= '{src: cur_src_q, key: in_key};
									state_q           <= S_POP_RD;
								end else begin
									state_q <= S_REP_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_BLD_CHK: begin
					if (scan_q == limit) begin
						state_q <= S_REP_RD;
					end else if (live_q[scan_q[SRC_W-1:0]]) begin
						state_q <= S_BLD_LD;
					end else begin
						scan_q <= scan_q + FILL_W'(1);
					end
				end
				S_BLD_LD: begin
					x_q     <= '{src: scan_q[SRC_W-1:0], key: key_rd_q};
					p_q     <= SRC_W'(fill_q);
					fill_q  <= fill_q + FILL_W'(1);
					scan_q  <= scan_q + FILL_W'(1);
					state_q <= S_SU_RD;
				end
				S_SU_RD: begin
					if (p_q == '0) begin
						state_q <= build_mode_q ? S_BLD_CHK : S_REP_RD;
					end else begin
						state_q <= S_SU_CMP;
					end
				end
				S_SU_CMP: begin
					if (cmp_lt) begin
						p_q     <= par;
						state_q <= S_SU_RD;
					end else begin
						state_q <= build_mode_q ? S_BLD_CHK : S_REP_RD;
					end
				end
				S_POP_RD: begin
					fill_q  <= fill_q - FILL_W'(1);
					state_q <= S_POP_LD;
				end
				S_POP_LD: begin
					// last entry becomes the hole filler at the root
					x_q     <= hrd_q;
					p_q     <= '0;
					state_q <= S_SD_RDL;
				end
				S_SD_RDL: begin
					state_q <= l_ok ? S_SD_RDR : S_PUSH;
				end
				S_SD_RDR: begin
					c_q     <= hrd_q;
					cpos_q  <= SRC_W'(l_w);
					state_q <= r_ok ? S_SD_CMPR : S_SD_CMPP;
				end
				S_SD_CMPR: begin
					if (cmp_lt) begin
						c_q    <= hrd_q;
						cpos_q <= cpos_q + SRC_W'(1);
					end
					state_q <= S_SD_CMPP;
				end
				S_SD_CMPP: begin
					if (cmp_lt) begin
						p_q     <= cpos_q;
						state_q <= S_SD_RDL;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (present_q) begin
						x_q     <= new_ent_q;
						p_q     <= SRC_W'(fill_q);
						fill_q  <= fill_q + FILL_W'(1);
						state_q <= S_SU_RD;
					end else begin
						state_q <= S_REP_RD;
					end
				end
				S_REP_RD: begin
					state_q <= S_REP_OUT;
				end
				S_REP_OUT: begin
					if (rep_load) begin
						cur_valid_q <= (fill_q != '0);
						if (fill_q != '0) begin
							cur_src_q <= hrd_q.src;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rep_load) begin
			if (fill_q != '0) begin
				out_q.has_winner   <= 1'b1;
				out_q.winner_index <= 4'(hrd_q.src);
				out_q.winner_key   <= 64'(hrd_q.key);
			end else begin
				out_q.has_winner   <= 1'b0;
				out_q.winner_index <= '0;
				out_q.winner_key   <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_SOURCES)
		else $error("heap fill above source capacity");

	a_cur_has_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cur_valid_q) |-> (fill_q != '0))
		else $error("current winner without heap entries");

	a_result_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_REP_OUT))
		else $error("result raised outside report step");

	a_siftup_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SU_RD) |-> (32'(p_q) < 32'(fill_q)))
		else $error("sift-up position beyond heap fill");

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.has_winner) |->
			(out_q.winner_index == '0 && out_q.winner_key == '0))
		else $error("empty result carries a source");
`endif

endmodule
`default_nettype wire
